// ----- hw/rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, payload types, register indexes and reset values for the
// escape-time unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int COORD_FRAC_BITS = 60;
  localparam int PIXEL_BITS      = 12;
  localparam int ITER_BITS       = 16;

  // fixed field widths
  localparam int COORD_W = 64;
  localparam int STEP_W  = 63;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;

  // pixel mapping
  localparam int PROD_W = PIXEL_BITS + STEP_W;
  localparam int MAP_W  = PROD_W + 1;

  // iteration datapath: x, y signed; x2, y2 non-negative
  localparam int X_W    = COORD_FRAC_BITS + 8;
  localparam int OP_W   = X_W + 1;
  localparam int RES_W  = COORD_FRAC_BITS + 10;
  localparam int SQ_W   = RES_W;
  localparam int HALF_W = (OP_W + 1) / 2;
  localparam int MAG_W  = 2 * HALF_W;
  localparam int ACC_W  = 2 * MAG_W;

  // job queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [IDX_W-1:0] {
    REG_ORIGIN_RE = 3'd0,
    REG_ORIGIN_IM = 3'd1,
    REG_STEP_RE   = 3'd2,
    REG_STEP_IM   = 3'd3,
    REG_MAX_ITER  = 3'd4
  } reg_idx_t;

  localparam logic signed [COORD_W-1:0] ORIGIN_RE_RST = 64'shE000_0000_0000_0000;
  localparam logic signed [COORD_W-1:0] ORIGIN_IM_RST = 64'shE800_0000_0000_0000;
  localparam logic [STEP_W-1:0]         STEP_RE_RST   = 63'd3377699720527872;
  localparam logic [STEP_W-1:0]         STEP_IM_RST   = 63'd3377699720527872;
  localparam logic [ITER_BITS-1:0]      MAX_ITER_RST  = ITER_BITS'(256);

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_col;
    logic [PIXEL_BITS-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] out_col;
    logic [PIXEL_BITS-1:0] out_row;
    logic [ITER_BITS-1:0]  iteration_count;
    logic                  escaped;
  } result_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0]     col;
    logic [PIXEL_BITS-1:0]     row;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } job_t;

endpackage

// ----- hw/rtl/mbe_front.sv -----
// ----------------------------------------------------------------------------
// mbe_front
// Takes a pixel, maps it to the point c and pushes the job into the queue.
// ----------------------------------------------------------------------------
module mbe_front import mbe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  pixel_t                    pixel,
  input  logic signed [COORD_W-1:0] origin_re,
  input  logic signed [COORD_W-1:0] origin_im,
  input  logic [STEP_W-1:0]         step_re,
  input  logic [STEP_W-1:0]         step_im,
  input  logic                      q_full,
  output logic                      busy,
  output logic                      push,
  output job_t                      job
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_ADD  = 3'b100
  } fstate_t;

  fstate_t state;
  fstate_t state_next;

  logic [PIXEL_BITS-1:0] col;
  logic [PIXEL_BITS-1:0] row;
  logic [PROD_W-1:0]     prod_re;
  logic [PROD_W-1:0]     prod_im;
  logic signed [MAP_W-1:0] sum_re;
  logic signed [MAP_W-1:0] sum_im;

  // saturate to the largest positive coordinate when the sum leaves 64 bits
  function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [MAP_W-1:0] s);
    logic [MAP_W-COORD_W:0] top;
    top = s[MAP_W-1:COORD_W-1];
    if (top != '0 && top != '1) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
    return s[COORD_W-1:0];
  endfunction

  assign sum_re = $signed({1'b0, prod_re}) + MAP_W'(origin_re);
  assign sum_im = $signed({1'b0, prod_im}) + MAP_W'(origin_im);

  assign busy = (state != F_IDLE);
  assign push = (state == F_ADD) && !q_full;

  always_comb begin
    job.col = col;
    job.row = row;
    job.cx  = sat_coord(sum_re);
    job.cy  = sat_coord(sum_im);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (start) state_next = F_MUL;
      F_MUL:  state_next = F_ADD;
      F_ADD:  if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      col <= pixel.pixel_col;
      row <= pixel.pixel_row;
    end
    if (state == F_MUL) begin
      prod_re <= PROD_W'(col) * PROD_W'(step_re);
      prod_im <= PROD_W'(row) * PROD_W'(step_im);
    end
  end

endmodule

// ----- hw/rtl/mbe_queue.sv -----
// ----------------------------------------------------------------------------
// mbe_queue
// Short FIFO of mapped jobs between the front and the iteration engine.
// ----------------------------------------------------------------------------
module mbe_queue import mbe_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  job_t   wdata,
  input  logic   pop,
  output job_t   rdata,
  output logic   full,
  output logic   empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// ----- hw/rtl/mbe_mul.sv -----
// ----------------------------------------------------------------------------
// mbe_mul
// Sequential fixed-point multiplier: floor(a * b / 2^F), four half-width
// partial products, one per cycle, into a wide accumulator.
// ----------------------------------------------------------------------------
module mbe_mul import mbe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [OP_W-1:0] a,
  input  logic signed [OP_W-1:0] b,
  output logic                   done,
  output logic signed [RES_W-1:0] prod
);

  localparam logic [2:0] PH_PARTS = 3'd4;
  localparam logic [2:0] PH_LAST  = 3'd5;

  logic [MAG_W-1:0]    ma;
  logic [MAG_W-1:0]    mb;
  logic                neg;
  logic                run;
  logic [2:0]          ph;
  logic [2*HALF_W-1:0] pp;
  logic [1:0]          pp_sh;
  logic                pp_v;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    pp_ext;
  logic [ACC_W-1:0]    acc_fin;
  logic [OP_W-1:0]     abs_a;
  logic [OP_W-1:0]     abs_b;
  logic [HALF_W-1:0]   a_part;
  logic [HALF_W-1:0]   b_part;

  assign abs_a  = a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
  assign abs_b  = b[OP_W-1] ? OP_W'(-b) : OP_W'(b);
  assign a_part = ph[1] ? ma[MAG_W-1:HALF_W] : ma[HALF_W-1:0];
  assign b_part = ph[0] ? mb[MAG_W-1:HALF_W] : mb[HALF_W-1:0];

  always_comb begin
    unique case (pp_sh)
      2'd0:    pp_ext = ACC_W'(pp);
      2'd1:    pp_ext = ACC_W'(pp) << HALF_W;
      default: pp_ext = ACC_W'(pp) << (2 * HALF_W);
    endcase
  end

  // negate the exact product, then drop fraction bits: floor for both signs
  assign acc_fin = neg ? ACC_W'(-acc) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      pp_v <= 1'b0;
      done <= 1'b0;
      ph   <= '0;
    end else begin
      done <= 1'b0;
      if (start && !run) begin
        run  <= 1'b1;
        pp_v <= 1'b0;
        ph   <= '0;
      end else if (run) begin
        pp_v <= (ph < PH_PARTS);
        ph   <= ph + 1'b1;
        if (ph == PH_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !run) begin
      ma  <= MAG_W'(abs_a);
      mb  <= MAG_W'(abs_b);
      neg <= a[OP_W-1] ^ b[OP_W-1];
      acc <= '0;
    end else if (run) begin
      pp    <= a_part * b_part;
      pp_sh <= {1'b0, ph[1]} + {1'b0, ph[0]};
      if (pp_v) acc <= acc + pp_ext;
      if (ph == PH_LAST) prod <= acc_fin[COORD_FRAC_BITS +: RES_W];
    end
  end

endmodule

// ----- hw/rtl/mbe_back.sv -----
// ----------------------------------------------------------------------------
// mbe_back
// Iteration engine: pops a job, runs z = z^2 + c on the shared multiplier
// and emits the result word.
// ----------------------------------------------------------------------------
module mbe_back import mbe_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  job_t                 job,
  input  logic [ITER_BITS-1:0] max_iterations,
  output logic                 pop,
  output logic                 done,
  output result_t              result
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_CHECK = 5'b00010,
    B_MXY   = 5'b00100,
    B_MXX   = 5'b01000,
    B_MYY   = 5'b10000
  } bstate_t;

  localparam logic [SQ_W:0] FOUR = (SQ_W+1)'(4) << COORD_FRAC_BITS;

  bstate_t state;
  bstate_t state_next;

  logic [PIXEL_BITS-1:0]     col;
  logic [PIXEL_BITS-1:0]     row;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic signed [X_W-1:0]     x;
  logic signed [X_W-1:0]     y;
  logic [SQ_W-1:0]           x2;
  logic [SQ_W-1:0]           y2;
  logic [ITER_BITS-1:0]      it;

  logic [SQ_W:0]             mag;
  logic                      esc;
  logic                      stop;
  logic signed [SQ_W+1:0]    x_new;
  logic signed [X_W-1:0]     y_new;

  logic                      m_start;
  logic signed [OP_W-1:0]    m_a;
  logic signed [OP_W-1:0]    m_b;
  logic                      m_done;
  logic signed [RES_W-1:0]   m_prod;

  mbe_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (m_start),
    .a     (m_a),
    .b     (m_b),
    .done  (m_done),
    .prod  (m_prod)
  );

  assign mag   = {1'b0, x2} + {1'b0, y2};
  assign esc   = (mag >= FOUR);
  assign stop  = esc || (it >= max_iterations);
  assign x_new = $signed({2'b00, x2}) - $signed({2'b00, y2}) + (SQ_W+2)'(cx);
  assign y_new = X_W'(m_prod) + X_W'(cy);
  assign pop   = (state == B_IDLE) && !q_empty;

  // operand select: 2x*y from the check, then x*x, then y*y
  always_comb begin
    m_start = 1'b0;
    m_a     = OP_W'(y);
    m_b     = OP_W'(y);
    unique case (state)
      B_CHECK: begin
        m_start = !stop;
        m_a     = {x, 1'b0};
      end
      B_MXY: begin
        m_start = m_done;
        m_a     = OP_W'(x);
        m_b     = OP_W'(x);
      end
      B_MXX: m_start = m_done;
      default: m_start = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!q_empty) state_next = B_CHECK;
      B_CHECK: state_next = stop ? B_IDLE : B_MXY;
      B_MXY:   if (m_done) state_next = B_MXX;
      B_MXX:   if (m_done) state_next = B_MYY;
      B_MYY:   if (m_done) state_next = B_CHECK;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == B_CHECK) && stop;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        col <= job.col;
        row <= job.row;
        cx  <= job.cx;
        cy  <= job.cy;
        x   <= '0;
        y   <= '0;
        x2  <= '0;
        y2  <= '0;
        it  <= '0;
      end
      B_CHECK: begin
        if (stop) begin
          result.out_col         <= col;
          result.out_row         <= row;
          result.iteration_count <= it;
          result.escaped         <= esc;
        end else begin
          x <= X_W'(x_new);
        end
      end
      B_MXY: if (m_done) y  <= y_new;
      B_MXX: if (m_done) x2 <= SQ_W'(m_prod);
      B_MYY: begin
        if (m_done) begin
          y2 <= SQ_W'(m_prod);
          it <= it + 1'b1;
        end
      end
      default: it <= it;
    endcase
  end

endmodule

// ----- hw/rtl/mandelbrot_escape_time_unit.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time engine: pixel -> point c, iterate z = z^2 + c, report count.
// ----------------------------------------------------------------------------
//  channel   ports                          timing
//  pixel in  start, busy, pixel             taken when start & !busy
//  result    done, result                   one cycle per word, no stall
//  config    wr_en, wr_index, wr_data       written at any edge with wr_en
//
//  Front captures a pixel, scales it by the step and adds the origin; a
//  2-entry queue decouples it from the iteration engine. One iteration is
//  three passes of the shared multiplier plus the escape check. busy holds
//  while the front has a pixel, longer when the queue is full. Reset
//  restores register defaults and empties the queue.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit import mbe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pixel_t           pixel,
  output logic             done,
  output result_t          result,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data
);

  logic signed [COORD_W-1:0] origin_re;
  logic signed [COORD_W-1:0] origin_im;
  logic [STEP_W-1:0]         step_re;
  logic [STEP_W-1:0]         step_im;
  logic [ITER_BITS-1:0]      max_iterations;

  logic   q_push;
  logic   q_full;
  job_t   f_job;
  job_t   q_job;
  logic   q_empty;
  logic   q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_re      <= ORIGIN_RE_RST;
      origin_im      <= ORIGIN_IM_RST;
      step_re        <= STEP_RE_RST;
      step_im        <= STEP_IM_RST;
      max_iterations <= MAX_ITER_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ORIGIN_RE: origin_re      <= wr_data;
        REG_ORIGIN_IM: origin_im      <= wr_data;
        REG_STEP_RE:   step_re        <= wr_data[STEP_W-1:0];
        REG_STEP_IM:   step_im        <= wr_data[STEP_W-1:0];
        REG_MAX_ITER:  max_iterations <= wr_data[ITER_BITS-1:0];
        default:       max_iterations <= max_iterations;
      endcase
    end
  end

  mbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .pixel     (pixel),
    .origin_re (origin_re),
    .origin_im (origin_im),
    .step_re   (step_re),
    .step_im   (step_im),
    .q_full    (q_full),
    .busy      (busy),
    .push      (q_push),
    .job       (f_job)
  );

  mbe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (f_job),
    .pop   (q_pop),
    .rdata (q_job),
    .full  (q_full),
    .empty (q_empty)
  );

  mbe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .job            (q_job),
    .max_iterations (max_iterations),
    .pop            (q_pop),
    .done           (done),
    .result         (result)
  );

endmodule

// ----- hw/rtl/mbe_checker.sv -----
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks on the escape-time unit, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker import mbe_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input result_t          result,
  input logic             wr_en,
  input logic [IDX_W-1:0] wr_index,
  input logic [CFG_W-1:0] wr_data
);

  logic [ITER_BITS-1:0] lim;

  // shadow of the iteration limit
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= MAX_ITER_RST;
    end else if (wr_en && wr_index == REG_MAX_ITER) begin
      lim <= wr_data[ITER_BITS-1:0];
    end
  end

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !done && !busy)
    else $error("done or busy set right after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted pixel did not raise busy");

  a_count_le_lim: assert property (@(posedge clk) disable iff (rst)
    done |-> result.iteration_count <= lim)
    else $error("iteration count above limit");

  a_inside_at_lim: assert property (@(posedge clk) disable iff (rst)
    done && !result.escaped |-> result.iteration_count == lim)
    else $error("non-escaped word stopped short of the limit");

  a_escape_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && result.escaped |-> result.iteration_count != '0)
    else $error("escape reported with zero iterations");

endmodule

bind mandelbrot_escape_time_unit mbe_checker u_mbe_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .result   (result),
  .wr_en    (wr_en),
  .wr_index (wr_index),
  .wr_data  (wr_data)
);
